[hw/rtl/tar_pkg.sv]
// ---------------------------------------------------------------------------
// Tetrahedron aspect ratio: shared types and constants
// Edge and cross-product index tables and the control word that travels with
// each tetrahedron down the pipeline.
// ---------------------------------------------------------------------------
package tar_pkg;

    localparam int RATIO_INT_BITS = 8;
    localparam int NUM_VERTS      = 4;
    localparam int NUM_AXES       = 3;
    localparam int NUM_EDGES      = 6;
    localparam int NUM_FACES      = 4;
    localparam int NUM_CROSS      = 5;

    // Edge e runs from vertex EDGE_FROM[e] to vertex EDGE_TO[e].
    localparam int EDGE_FROM [NUM_EDGES] = '{0, 0, 0, 1, 1, 2};
    localparam int EDGE_TO   [NUM_EDGES] = '{1, 2, 3, 2, 3, 3};

    // Cross products as pairs of edges. The first four are the face normals
    // (only their squared length is used, so edge signs do not matter); the
    // last one is AC x AD for the triple product.
    localparam int CROSS_U [NUM_CROSS] = '{0, 3, 5, 2, 1};
    localparam int CROSS_V [NUM_CROSS] = '{1, 4, 1, 4, 2};
    localparam int TRIPLE_CROSS        = 4;
    localparam int EDGE_AB             = 0;

    localparam int AXIS_NEXT [NUM_AXES] = '{1, 2, 0};
    localparam int AXIS_PREV [NUM_AXES] = '{2, 0, 1};

    typedef struct packed {
        logic valid;
        logic degenerate;
        logic saturate;
    } t_ctl;

endpackage

[hw/rtl/tar_front.sv]
// ---------------------------------------------------------------------------
// Tetrahedron aspect ratio: geometry front end
// Ten register stages from the four vertices to the exact integer numerator
// x = 2 * Lmax^2 * Nmax^2 * 2^(2F) and denominator y = 3 * T^2.
// ---------------------------------------------------------------------------
module tar_front import tar_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16,
    localparam int XW = 6 * COORD_BITS + 7 + 2 * RATIO_FRAC_BITS,
    localparam int YW = 6 * COORD_BITS + 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_p [NUM_VERTS][NUM_AXES],
    output t_ctl                         o_ctl,
    output logic        [XW-1:0]         o_x,
    output logic        [YW-1:0]         o_y
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = 2 * C;
    localparam int LW   = 2 * C + 2;
    localparam int CW   = 2 * C + 2;
    localparam int CW2  = 2 * CW;
    localparam int QW   = 2 * CW - 2;
    localparam int NW   = QW + 2;
    localparam int TPW  = DW + CW;
    localparam int TW   = TPW + 2;
    localparam int TMW  = TW - 1;
    localparam int TL   = (TMW + 1) / 2;
    localparam int TH   = TMW - TL;
    localparam int THH  = 2 * TH;
    localparam int THL  = TH + TL;
    localparam int TLL  = 2 * TL;
    localparam int T2W  = 2 * TMW;
    localparam int NL   = (NW + 1) / 2;
    localparam int NH   = NW - NL;
    localparam int PLW  = LW + NL;
    localparam int PHW  = LW + NH;
    localparam int SHIFT_X = 2 * RATIO_FRAC_BITS + 1;

    logic        [9:0]      r_vld;
    logic signed [C-1:0]    r_p    [NUM_VERTS][NUM_AXES];
    logic signed [DW-1:0]   r_e    [NUM_EDGES][NUM_AXES];
    logic        [SW-1:0]   r_sq   [NUM_EDGES][NUM_AXES];
    logic signed [PW-1:0]   r_xa   [NUM_CROSS][NUM_AXES];
    logic signed [PW-1:0]   r_xb   [NUM_CROSS][NUM_AXES];
    logic signed [DW-1:0]   r_eab3 [NUM_AXES];
    logic signed [DW-1:0]   r_eab4 [NUM_AXES];
    logic        [LW-1:0]   r_lsum [NUM_EDGES];
    logic signed [CW-1:0]   r_cr   [NUM_CROSS][NUM_AXES];
    logic        [LW-1:0]   r_lh   [2];
    logic        [QW-1:0]   r_csq  [NUM_FACES][NUM_AXES];
    logic signed [TPW-1:0]  r_tp   [NUM_AXES];
    logic        [LW-1:0]   r_lmax;
    logic        [NW-1:0]   r_nsum [NUM_FACES];
    logic signed [TW-1:0]   r_tsum;
    logic        [NW-1:0]   r_nh   [2];
    logic        [TMW-1:0]  r_tmag;
    logic        [LW-1:0]   r_lmax7;
    logic        [NW-1:0]   r_nmax;
    logic        [THH-1:0]  r_thh;
    logic        [THL-1:0]  r_thl;
    logic        [TLL-1:0]  r_tll;
    logic        [LW-1:0]   r_lmax8;
    logic                   r_dg8;
    logic        [T2W-1:0]  r_t2;
    logic        [PLW-1:0]  r_pl;
    logic        [PHW-1:0]  r_ph;
    logic                   r_dg9;
    logic        [XW-1:0]   r_x;
    logic        [YW-1:0]   r_y;
    logic                   r_dg10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[8:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= i_p;

        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_e[e][k] <= DW'(r_p[EDGE_TO[e]][k]) - DW'(r_p[EDGE_FROM[e]][k]);
            end
        end

        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_sq[e][k] <= SW'(PW'(r_e[e][k]) * PW'(r_e[e][k]));
            end
        end
        for (int c = 0; c < NUM_CROSS; c++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_xa[c][k] <= PW'(r_e[CROSS_U[c]][AXIS_NEXT[k]])
                              * PW'(r_e[CROSS_V[c]][AXIS_PREV[k]]);
                r_xb[c][k] <= PW'(r_e[CROSS_U[c]][AXIS_PREV[k]])
                              * PW'(r_e[CROSS_V[c]][AXIS_NEXT[k]]);
            end
        end
        r_eab3 <= r_e[EDGE_AB];

        for (int e = 0; e < NUM_EDGES; e++) begin
            r_lsum[e] <= LW'(r_sq[e][0]) + LW'(r_sq[e][1]) + LW'(r_sq[e][2]);
        end
        for (int c = 0; c < NUM_CROSS; c++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_cr[c][k] <= CW'(r_xa[c][k]) - CW'(r_xb[c][k]);
            end
        end
        r_eab4 <= r_eab3;

        for (int h = 0; h < 2; h++) begin
            if (r_lsum[3*h] >= r_lsum[3*h+1] && r_lsum[3*h] >= r_lsum[3*h+2]) begin
                r_lh[h] <= r_lsum[3*h];
            end else if (r_lsum[3*h+1] >= r_lsum[3*h+2]) begin
                r_lh[h] <= r_lsum[3*h+1];
            end else begin
                r_lh[h] <= r_lsum[3*h+2];
            end
        end
        for (int f = 0; f < NUM_FACES; f++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_csq[f][k] <= QW'(CW2'(r_cr[f][k]) * CW2'(r_cr[f][k]));
            end
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            r_tp[k] <= TPW'(r_eab4[k]) * TPW'(r_cr[TRIPLE_CROSS][k]);
        end

        r_lmax <= (r_lh[0] >= r_lh[1]) ? r_lh[0] : r_lh[1];
        for (int f = 0; f < NUM_FACES; f++) begin
            r_nsum[f] <= NW'(r_csq[f][0]) + NW'(r_csq[f][1]) + NW'(r_csq[f][2]);
        end
        r_tsum <= TW'(r_tp[0]) + TW'(r_tp[1]) + TW'(r_tp[2]);

        r_nh[0] <= (r_nsum[0] >= r_nsum[1]) ? r_nsum[0] : r_nsum[1];
        r_nh[1] <= (r_nsum[2] >= r_nsum[3]) ? r_nsum[2] : r_nsum[3];
        r_tmag  <= TMW'(r_tsum[TW-1] ? -r_tsum : r_tsum);
        r_lmax7 <= r_lmax;

        // |T|^2 is built from half-width partial products.
        r_nmax  <= (r_nh[0] >= r_nh[1]) ? r_nh[0] : r_nh[1];
        r_thh   <= THH'(r_tmag[TMW-1:TL]) * THH'(r_tmag[TMW-1:TL]);
        r_thl   <= THL'(r_tmag[TMW-1:TL]) * THL'(r_tmag[TL-1:0]);
        r_tll   <= TLL'(r_tmag[TL-1:0]) * TLL'(r_tmag[TL-1:0]);
        r_lmax8 <= r_lmax7;
        r_dg8   <= (r_tmag == '0);

        r_t2  <= (T2W'(r_thh) << (2 * TL)) + (T2W'(r_thl) << (TL + 1)) + T2W'(r_tll);
        r_pl  <= PLW'(r_lmax8) * PLW'(r_nmax[NL-1:0]);
        r_ph  <= PHW'(r_lmax8) * PHW'(r_nmax[NW-1:NL]);
        r_dg9 <= r_dg8;

        r_y    <= (YW'(r_t2) << 1) + YW'(r_t2);
        r_x    <= ((XW'(r_ph) << NL) + XW'(r_pl)) << SHIFT_X;
        r_dg10 <= r_dg9;
    end

    assign o_ctl = '{valid: r_vld[9], degenerate: r_dg10, saturate: r_dg10};
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

[hw/rtl/tar_root.sv]
// ---------------------------------------------------------------------------
// Tetrahedron aspect ratio: quotient and square root pipeline
// One overflow check stage, one stage per quotient bit of floor(x / y), then
// one stage per result bit of the integer square root of that quotient.
// ---------------------------------------------------------------------------
module tar_root import tar_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16,
    localparam int XW = 6 * COORD_BITS + 7 + 2 * RATIO_FRAC_BITS,
    localparam int YW = 6 * COORD_BITS + 10,
    localparam int RB = RATIO_INT_BITS + RATIO_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    output t_ctl          o_ctl,
    output logic [RB-1:0] o_ratio
);

    localparam int QB  = 2 * RB;
    localparam int RW  = YW + QB;
    localparam int SCW = (XW > RW) ? XW : RW;
    localparam int QW1 = QB + 1;

    t_ctl            r_c    [0:QB+RB];
    logic [RW-1:0]   r_rem  [0:QB];
    logic [YW-1:0]   r_y    [0:QB];
    logic [QB-1:0]   r_q    [0:QB];
    logic [QB-1:0]   r_sr   [1:RB];
    logic [RB-1:0]   r_root [1:RB];
    t_ctl            n_ctl0;

    // A quotient of 2^QB or more means the ratio does not fit.
    always_comb begin
        n_ctl0          = i_ctl;
        n_ctl0.saturate = i_ctl.saturate | (SCW'(i_x) >= (SCW'(i_y) << QB));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
        end else begin
            r_c[0] <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_x);
        r_y[0]   <= i_y;
        r_q[0]   <= '0;
    end

    for (genvar g = 1; g <= QB; g++) begin : g_div
        localparam int BIT = QB - g;
        logic [RW-1:0] n_sub;
        logic          n_take;

        assign n_sub  = RW'(r_y[g-1]) << BIT;
        assign n_take = (r_rem[g-1] >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[g] <= '0;
            end else begin
                r_c[g] <= r_c[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_take ? (r_rem[g-1] - n_sub) : r_rem[g-1];
            r_y[g]   <= r_y[g-1];
            r_q[g]   <= {r_q[g-1][QB-2:0], n_take};
        end
    end

    for (genvar h = 1; h <= RB; h++) begin : g_sqrt
        localparam int BIT = RB - h;
        logic [QB-1:0]  n_rem_in;
        logic [RB-1:0]  n_root_in;
        logic [QW1-1:0] n_sub;
        logic           n_take;

        if (h == 1) begin : g_first
            assign n_rem_in  = r_q[QB];
            assign n_root_in = '0;
        end else begin : g_next
            assign n_rem_in  = r_sr[h-1];
            assign n_root_in = r_root[h-1];
        end

        // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i), with no overlapping bits.
        assign n_sub  = (QW1'(n_root_in) << (BIT + 1)) | (QW1'(1) << (2 * BIT));
        assign n_take = (QW1'(n_rem_in) >= n_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[QB+h] <= '0;
            end else begin
                r_c[QB+h] <= r_c[QB+h-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sr[h]   <= n_take ? QB'(QW1'(n_rem_in) - n_sub) : n_rem_in;
            r_root[h] <= n_take ? (n_root_in | (RB'(1) << BIT)) : n_root_in;
        end
    end

    assign o_ctl   = r_c[QB+RB];
    assign o_ratio = r_c[QB+RB].saturate ? '1 : r_root[RB];

endmodule

[hw/rtl/tetrahedron_aspect_ratio_unit.sv]
// ---------------------------------------------------------------------------
// Tetrahedron aspect ratio unit
// Returns sqrt(2/3) * longest edge / smallest height of one tetrahedron as
// unsigned fixed point, exactly truncated, saturated, with a degenerate flag.
// ---------------------------------------------------------------------------
//  Channel   Handshake         Payload
//  -------   ---------------   -------------------------------------------
//  input     start / busy      i_ax .. i_dz, four vertices, signed coords
//  result    o_strobe          o_ratio (Q8.F), o_degenerate
//
//  One tetrahedron can be transferred in every cycle; busy is high only in
//  reset. The result strobe follows the transfer through ten geometry stages,
//  one overflow check, one stage per quotient bit, one per root bit and the
//  output register.
//  Synchronous reset clears the valid and control flags only. The receiver cannot stall.
// ---------------------------------------------------------------------------
module tetrahedron_aspect_ratio_unit import tar_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         start,
    output logic                                         busy,
    input  logic signed [COORD_BITS-1:0]                 i_ax,
    input  logic signed [COORD_BITS-1:0]                 i_ay,
    input  logic signed [COORD_BITS-1:0]                 i_az,
    input  logic signed [COORD_BITS-1:0]                 i_bx,
    input  logic signed [COORD_BITS-1:0]                 i_by_coord,
    input  logic signed [COORD_BITS-1:0]                 i_bz,
    input  logic signed [COORD_BITS-1:0]                 i_cx,
    input  logic signed [COORD_BITS-1:0]                 i_cy,
    input  logic signed [COORD_BITS-1:0]                 i_cz,
    input  logic signed [COORD_BITS-1:0]                 i_dx,
    input  logic signed [COORD_BITS-1:0]                 i_dy,
    input  logic signed [COORD_BITS-1:0]                 i_dz,
    output logic                                         o_strobe,
    output logic        [RATIO_INT_BITS+RATIO_FRAC_BITS-1:0] o_ratio,
    output logic                                         o_degenerate
);

    localparam int RB     = RATIO_INT_BITS + RATIO_FRAC_BITS;
    localparam int XW     = 6 * COORD_BITS + 7 + 2 * RATIO_FRAC_BITS;
    localparam int YW     = 6 * COORD_BITS + 10;
    localparam int STAGES = 12 + 3 * RB;

    logic signed [COORD_BITS-1:0] coord [NUM_VERTS][NUM_AXES];
    logic                         take;
    t_ctl                         front_ctl;
    t_ctl                         root_ctl;
    logic [XW-1:0]                num_x;
    logic [YW-1:0]                den_y;
    logic [RB-1:0]                root_ratio;
    logic                         r_strobe;
    logic [RB-1:0]                r_ratio;
    logic                         r_degenerate;

    assign busy = ~i_rst_n;
    assign take = start & ~busy;

    assign coord[0][0] = i_ax;
    assign coord[0][1] = i_ay;
    assign coord[0][2] = i_az;
    assign coord[1][0] = i_bx;
    assign coord[1][1] = i_by_coord;
    assign coord[1][2] = i_bz;
    assign coord[2][0] = i_cx;
    assign coord[2][1] = i_cy;
    assign coord[2][2] = i_cz;
    assign coord[3][0] = i_dx;
    assign coord[3][1] = i_dy;
    assign coord[3][2] = i_dz;

    tar_front #(
        .COORD_BITS      (COORD_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (take),
        .i_p     (coord),
        .o_ctl   (front_ctl),
        .o_x     (num_x),
        .o_y     (den_y)
    );

    tar_root #(
        .COORD_BITS      (COORD_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (front_ctl),
        .i_x     (num_x),
        .i_y     (den_y),
        .o_ctl   (root_ctl),
        .o_ratio (root_ratio)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= root_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio      <= root_ratio;
        r_degenerate <= root_ctl.degenerate;
    end

    assign o_strobe     = r_strobe;
    assign o_ratio      = r_ratio;
    assign o_degenerate = r_degenerate;

endmodule

[hw/rtl/tar_checker.sv]
// ---------------------------------------------------------------------------
// Tetrahedron aspect ratio: port checker
// Watches the top-level ports for latency, reset and flag consistency.
// ---------------------------------------------------------------------------
module tar_checker #(
    parameter int STAGES     = 84,
    parameter int RATIO_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_strobe,
    input logic [RATIO_BITS-1:0] o_ratio,
    input logic                  o_degenerate
);

    // Every result goes back to a transfer a fixed number of cycles earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, STAGES))
        else $error("result strobe without a matching input transfer");

    a_degenerate_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_degenerate) |-> (&o_ratio))
        else $error("degenerate result without a saturated ratio");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_never_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy outside reset");

endmodule

bind tetrahedron_aspect_ratio_unit tar_checker #(
    .STAGES     (STAGES),
    .RATIO_BITS (RB)
) u_tar_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_ratio      (o_ratio),
    .o_degenerate (o_degenerate)
);
